// ===== rtl/sqlm_pkg.sv =====
package sqlm_pkg;

    localparam int MaxPatternBytes = 32;
    localparam int VecWidth = MaxPatternBytes + 1;
    localparam int ScanLevels = $clog2(VecWidth);
    localparam int LenWidth = 6;
    localparam int NumWords = 4;
    localparam int WordWidth = 64;
    localparam int CfgIndexWidth = 3;

    localparam logic [CfgIndexWidth-1:0] REG_PATTERN_WORD_0 = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_PATTERN_WORD_1 = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_PATTERN_WORD_2 = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_PATTERN_WORD_3 = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_PATTERN_LENGTH = 3'd4;

    localparam logic [7:0] WildAny = 8'h25;
    localparam logic [7:0] WildOne = 8'h5F;

    typedef logic [VecWidth-1:0] vec_t;

    // Bit j of each mask refers to pattern byte j-1; bit 0 is never set.
    typedef struct packed {
        logic [MaxPatternBytes-1:0][7:0] bytes;
        vec_t                            active;
        vec_t                            any_mask;
        vec_t                            one_mask;
        logic [LenWidth-1:0]             len;
    } pattern_t;

    // Each '%' position takes the bit of the prefix before it, as a parallel prefix scan.
    function automatic vec_t closure(input vec_t base, input vec_t pass);
        vec_t g;
        vec_t p;
        vec_t g_new;
        vec_t p_new;
        int   d;
        g = base;
        p = pass;
        for (int lvl = 0; lvl < ScanLevels; lvl++) begin
            d = 1 << lvl;
            g_new = g;
            p_new = p;
            for (int j = 0; j < VecWidth; j++) begin
                if (j >= d) begin
                    g_new[j] = g[j] | (p[j] & g[j-d]);
                    p_new[j] = p[j] & p[j-d];
                end
            end
            g = g_new;
            p = p_new;
        end
        return g;
    endfunction

    function automatic vec_t advance(input vec_t old, input pattern_t pat,
                                     input logic [7:0] c);
        vec_t b;
        b = '0;
        for (int j = 1; j < VecWidth; j++) begin
            if (pat.any_mask[j]) begin
                b[j] = old[j];
            end else if (pat.active[j] && (pat.one_mask[j] || pat.bytes[j-1] == c)) begin
                b[j] = old[j-1];
            end
        end
        return closure(b, pat.any_mask);
    endfunction

endpackage

// ===== rtl/sqlm_pattern_regs.sv =====
module sqlm_pattern_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [sqlm_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [sqlm_pkg::WordWidth-1:0]       cfg_data,
    output sqlm_pkg::pattern_t                   pattern
);

    logic [sqlm_pkg::NumWords-1:0][sqlm_pkg::WordWidth-1:0] words_reg;
    logic [sqlm_pkg::LenWidth-1:0]                          len_reg;
    logic [sqlm_pkg::LenWidth-1:0]                          len_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_reg <= '0;
            len_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                sqlm_pkg::REG_PATTERN_WORD_0: words_reg[0] <= cfg_data;
                sqlm_pkg::REG_PATTERN_WORD_1: words_reg[1] <= cfg_data;
                sqlm_pkg::REG_PATTERN_WORD_2: words_reg[2] <= cfg_data;
                sqlm_pkg::REG_PATTERN_WORD_3: words_reg[3] <= cfg_data;
                sqlm_pkg::REG_PATTERN_LENGTH: len_reg <= cfg_data[sqlm_pkg::LenWidth-1:0];
                default: ;
            endcase
        end
    end

    assign len_eff = (len_reg > sqlm_pkg::LenWidth'(sqlm_pkg::MaxPatternBytes))
                   ? sqlm_pkg::LenWidth'(sqlm_pkg::MaxPatternBytes) : len_reg;

    always_comb
    begin
        pattern = '0;
        pattern.len = len_eff;
        for (int k = 0; k < sqlm_pkg::MaxPatternBytes; k++)
        begin
            pattern.bytes[k] = words_reg[k / 8][8 * (k % 8) +: 8];
        end
        for (int j = 1; j < sqlm_pkg::VecWidth; j++)
        begin
            pattern.active[j]   = (sqlm_pkg::LenWidth'(j) <= len_eff);
            pattern.any_mask[j] = pattern.active[j]
                                && (pattern.bytes[j-1] == sqlm_pkg::WildAny);
            pattern.one_mask[j] = pattern.active[j]
                                && (pattern.bytes[j-1] == sqlm_pkg::WildOne);
        end
    end

endmodule

// ===== rtl/sqlm_prefix_vector.sv =====
module sqlm_prefix_vector (
    input  logic               clk,
    input  logic               rst_n,
    input  sqlm_pkg::pattern_t pattern,
    input  logic               update,
    input  logic [7:0]         subject_byte,
    input  logic               byte_present,
    input  logic               end_of_string,
    output logic               matched_next
);

    sqlm_pkg::vec_t vec_reg;
    sqlm_pkg::vec_t vec_next;
    sqlm_pkg::vec_t start_vec;
    logic           at_start_reg;

    assign start_vec = at_start_reg
                     ? sqlm_pkg::closure(sqlm_pkg::vec_t'(1), pattern.any_mask)
                     : vec_reg;
    assign vec_next = byte_present
                    ? sqlm_pkg::advance(start_vec, pattern, subject_byte)
                    : start_vec;
    assign matched_next = vec_next[pattern.len];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg      <= '0;
            at_start_reg <= 1'b1;
        end
        else if (update)
        begin
            vec_reg      <= vec_next;
            at_start_reg <= end_of_string;
        end
    end

endmodule

// ===== rtl/sql_like_wildcard_matcher_top.sv =====
// SQL LIKE matcher for a streamed subject string.
// The pattern must be loaded through the configuration port (four pattern words and
// a length) only while the block is idle; the block itself does not enforce this.
// Subject requests arrive on the subject channel, one byte per request; the last
// request of a string carries end_of_string, and an empty string is sent as a
// single end request without a byte. Requests with neither a byte nor an end mark
// are taken and dropped. One result request carrying matched leaves on the result
// channel per string, registered as its end request leaves the input register.
// The block takes one subject request in every cycle while the result channel does
// not stall; the prefix vector is updated once per byte by a single registered
// step, and that loop sets the rate. When the receiver stalls, the result is held
// and the request waiting in the input register stays there, so subject_stall
// rises in the same cycle. Reset clears the pattern, empties both registers and
// prepares the vector for the start of a new string.
module sql_like_wildcard_matcher_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [sqlm_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [sqlm_pkg::WordWidth-1:0]     cfg_data,
    input  logic                               subject_valid,
    output logic                               subject_stall,
    input  logic [7:0]                         subject_byte,
    input  logic                               byte_present,
    input  logic                               end_of_string,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic                               matched
);

    sqlm_pkg::pattern_t pattern;
    logic               s1_valid_reg;
    logic [7:0]         s1_byte_reg;
    logic               s1_present_reg;
    logic               s1_last_reg;
    logic               result_valid_reg;
    logic               matched_reg;
    logic               matched_next;
    logic               advance;
    logic               accept;
    logic               fire;

    sqlm_pattern_regs u_pattern_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pattern      (pattern)
    );

    sqlm_prefix_vector u_prefix_vector (
        .clk           (clk),
        .rst_n         (rst_n),
        .pattern       (pattern),
        .update        (fire),
        .subject_byte  (s1_byte_reg),
        .byte_present  (s1_present_reg),
        .end_of_string (s1_last_reg),
        .matched_next  (matched_next)
    );

    assign advance       = !result_valid_reg || !result_stall;
    assign subject_stall = s1_valid_reg && !advance;
    assign accept        = subject_valid && !subject_stall;
    assign fire          = advance && s1_valid_reg;
    assign result_valid  = result_valid_reg;
    assign matched       = matched_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= byte_present || end_of_string;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                result_valid_reg <= s1_valid_reg && s1_last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg    <= subject_byte;
            s1_present_reg <= byte_present;
            s1_last_reg    <= end_of_string;
        end
        if (fire && s1_last_reg)
        begin
            matched_reg <= matched_next;
        end
    end

    a_no_empty_request: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_present_reg |-> s1_last_reg)
        else $error("Request without a byte or an end mark reached the vector update.");

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_last_reg |=> result_valid_reg)
        else $error("End of string did not produce a result.");

    a_result_only_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !(s1_valid_reg && s1_last_reg) |=> !result_valid_reg)
        else $error("Result appeared without an end-of-string request.");

endmodule
